[src/mef_pkg.sv]
package mef_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 9;
	localparam int M_TDATA_W     = 48;
	localparam int MAX_ITEMS_DEF = 256;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     store;
		logic                     last;
	} beat_t;

	typedef enum logic [5:0] {
		ST_LOAD   = 6'b000001,
		ST_OFETCH = 6'b000010,
		ST_OWAIT  = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_EMIT   = 6'b100000
	} back_state_t;

endpackage

[src/mef_front.sv]
module mef_front #(
	parameter int MAX_ITEMS = mef_pkg::MAX_ITEMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic signed [mef_pkg::DATA_W-1:0]   s_tdata,
	input  logic                                s_tlast,
	output logic                                push_valid,
	output mef_pkg::beat_t                      push_beat,
	input  logic                                push_ready
);
	import mef_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] fill_q;
	logic          room;

	// a beat past the store size is tagged for dropping
	assign room       = fill_q < CW'(MAX_ITEMS);
	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

	always_comb begin
		push_beat.value = s_tdata;
		push_beat.store = room;
		push_beat.last  = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (s_tvalid && push_ready) begin
			if (s_tlast) begin
				fill_q <= '0;
			end else if (room) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

endmodule

[src/mef_queue.sv]
module mef_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  mef_pkg::beat_t in_beat,
	output logic           in_ready,
	output logic           out_valid,
	output mef_pkg::beat_t out_beat,
	input  logic           out_ready
);
	import mef_pkg::*;

	beat_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       push;
	logic       pop;

	assign in_ready  = level_q != 2'd2;
	assign out_valid = level_q != 2'd0;
	assign out_beat  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

endmodule

[src/mef_back.sv]
module mef_back #(
	parameter int MAX_ITEMS = mef_pkg::MAX_ITEMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  mef_pkg::beat_t                     q_beat,
	output logic                               q_ready,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mef_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                               m_tuser
);
	import mef_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic signed [DATA_W-1:0] store_mem [MAX_ITEMS];
	logic signed [DATA_W-1:0] rdata_q;
	logic        [AW-1:0]     rd_addr;

	back_state_t              state_q;
	logic        [CW-1:0]     items_q;
	logic        [CW-1:0]     n_q;
	logic        [AW-1:0]     outer_q;
	logic        [AW-1:0]     inner_q;
	logic                     cmp_vld_q;
	logic        [CW-1:0]     run_q;
	logic        [CW-1:0]     best_q;
	logic signed [DATA_W-1:0] best_val_q;
	logic signed [DATA_W-1:0] outer_val_q;

	logic                     out_vld_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] value_q;
	logic [COUNT_OUT_W-1:0]   count_q;

	logic                     pop;
	logic                     eq;
	logic        [CW-1:0]     final_cnt;
	logic                     out_free;

	assign q_ready   = state_q == ST_LOAD;
	assign pop       = q_valid && q_ready;
	assign rd_addr   = (state_q == ST_OFETCH) ? outer_q : inner_q;
	assign eq        = rdata_q == outer_val_q;
	assign final_cnt = run_q + CW'(eq);
	assign out_free  = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(M_TDATA_W - DATA_W - COUNT_OUT_W){1'b0}}, count_q, value_q};

	always_ff @(posedge clk) begin
		if (pop && q_beat.store) begin
			store_mem[items_q[AW-1:0]] <= q_beat.value;
		end
		rdata_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OWAIT) begin
			outer_val_q <= rdata_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			found_q <= best_q > (n_q >> 1);
			value_q <= best_val_q;
			count_q <= COUNT_OUT_W'(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			items_q    <= '0;
			n_q        <= '0;
			outer_q    <= '0;
			inner_q    <= '0;
			cmp_vld_q  <= 1'b0;
			run_q      <= '0;
			best_q     <= '0;
			best_val_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (q_beat.store) begin
							items_q <= items_q + CW'(1);
						end
						if (q_beat.last) begin
							n_q        <= items_q + CW'(q_beat.store);
							outer_q    <= '0;
							best_q     <= '0;
							best_val_q <= '0;
							state_q    <= ST_OFETCH;
						end
					end
				end
				ST_OFETCH: begin
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					inner_q   <= '0;
					run_q     <= '0;
					cmp_vld_q <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					cmp_vld_q <= 1'b1;
					if (cmp_vld_q && eq) begin
						run_q <= run_q + CW'(1);
					end
					if (CW'(inner_q) == n_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end else begin
						inner_q <= inner_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (final_cnt > best_q) begin
						best_q     <= final_cnt;
						best_val_q <= outer_val_q;
					end
					if (CW'(outer_q) == n_q - CW'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						outer_q <= outer_q + AW'(1);
						state_q <= ST_OFETCH;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						items_q   <= '0;
						n_q       <= '0;
						outer_q   <= '0;
						inner_q   <= '0;
						run_q     <= '0;
						best_q    <= '0;
						best_val_q <= '0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[src/majority_element_finder_core.sv]
// channel  dir  tdata                                             tuser   tlast
// s_*      in   [31:0] element_value                               -       is_last
// m_*      out  [31:0] majority_value, [40:32] occurrence_count   found   -
//
// a list beat is stored as it is popped from the queue; after the last beat of a list
// the pairwise scan compares each stored element with every stored element through one
// registered read port, then the result register is loaded once the output is free
// reset clears control only; the element store holds nothing valid until written
// a two-beat queue keeps s_tready high while the scan runs until it fills;
// a held result stalls the scan only at its final step
module majority_element_finder_core #(
	parameter int MAX_ITEMS = mef_pkg::MAX_ITEMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mef_pkg::DATA_W-1:0]         s_tdata,   // [31:0] element_value
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mef_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] majority_value, [40:32] occurrence_count
	output logic                               m_tuser    // [0] found
);
	import mef_pkg::*;

	logic  push_valid;
	beat_t push_beat;
	logic  push_ready;
	logic  q_valid;
	beat_t q_beat;
	logic  q_ready;

	mef_front #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_beat  (push_beat),
		.push_ready (push_ready)
	);

	mef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_beat   (push_beat),
		.in_ready  (push_ready),
		.out_valid (q_valid),
		.out_beat  (q_beat),
		.out_ready (q_ready)
	);

	mef_back #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_beat   (q_beat),
		.q_ready  (q_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_result_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> q_ready)
		else $error("result issued while back end not loading");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> q_valid)
		else $error("queue full but shows no beat");

	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid)
		else $error("queued beat lost during scan");

endmodule

[verif/tb.sv]
module tb;
	import mef_pkg::*;

	localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
	localparam int TOTAL_BEATS  = 1880;
	localparam int QUIET_FROM   = 1700;
	localparam int LONG_HOLD    = 3000;
	localparam int SETTLE_WAIT  = 300;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic                   found;
		logic [DATA_W-1:0]      value;
		logic [COUNT_OUT_W-1:0] count;
	} majority_t;

	class majority_sb;
		logic [DATA_W-1:0] list_q[$];
		majority_t         expected_q[$];
		int                beats;
		int                lists;
		int                results;
		int                mismatches;

		function void note_beat(logic [DATA_W-1:0] value, logic last);
			majority_t              exp_r;
			logic [COUNT_OUT_W-1:0] run;
			int                     n;
			beats++;
			if (list_q.size() < MAX_ITEMS) begin
				list_q.insert(list_q.size(), value);
			end
			if (last) begin
				n = list_q.size();
				exp_r.count = '0;
				exp_r.value = '0;
				for (int o = 0; o < n; o++) begin
					run = '0;
					for (int i = 0; i < n; i++) begin
						if (list_q[i] == list_q[o]) begin
							run++;
						end
					end
					if (run > exp_r.count) begin
						exp_r.count = run;
						exp_r.value = list_q[o];
					end
				end
				exp_r.found = (int'(exp_r.count) > n / 2);
				expected_q.insert(expected_q.size(), exp_r);
				list_q.delete();
				lists++;
			end
		endfunction

		function void check_result(logic found, logic [DATA_W-1:0] value,
				logic [COUNT_OUT_W-1:0] count);
			majority_t exp_r;
			results++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected result: found=%0d value=%h count=%0d",
						found, value, count);
				end
				return;
			end
			exp_r = expected_q.pop_front();
			if (found !== exp_r.found || value !== exp_r.value || count !== exp_r.count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result %0d mismatch: exp found=%0d value=%h count=%0d, got found=%0d value=%h count=%0d",
						results, exp_r.found, exp_r.value, exp_r.count, found, value, count);
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tuser;

	majority_sb        sb = new;
	logic [DATA_W-1:0] list_buf[$];
	int                beats_sent;
	int                lists_sent;
	int                cycles;
	bit                quiet;
	bit                held_long;

	majority_element_finder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_beat(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata[DATA_W-1:0],
					m_tdata[DATA_W+COUNT_OUT_W-1:DATA_W]);
			end
		end
	end

	// receiver: random stall bursts plus one long hold to back up the input
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_long && sb.results >= 20) begin
				held_long = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic [DATA_W-1:0] value, input logic last);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_list();
		foreach (list_buf[i]) begin
			send_beat(list_buf[i], i == list_buf.size() - 1);
		end
		lists_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic shuffle_head(input int n);
		int                j;
		logic [DATA_W-1:0] tmp;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = list_buf[i];
			list_buf[i] = list_buf[j];
			list_buf[j] = tmp;
		end
	endtask

	task automatic build_list(input int len);
		logic [DATA_W-1:0] pick[4];
		int                kind;
		kind = $urandom_range(0, 3);
		foreach (pick[k]) begin
			pick[k] = $urandom;
		end
		if (kind == 3) begin
			pick[0] = 32'h8000_0000;
			pick[1] = 32'h7fff_ffff;
			pick[2] = 32'hffff_ffff;
			pick[3] = 32'h0000_0000;
		end
		list_buf.delete();
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: begin
					list_buf.insert(list_buf.size(), $urandom_range(0, 99) < 60 ? pick[0]
						: pick[$urandom_range(1, 3)]);
				end
				2: begin
					list_buf.insert(list_buf.size(), $urandom);
				end
				default: begin
					list_buf.insert(list_buf.size(),
						pick[$urandom_range(0, kind == 1 ? 2 : 3)]);
				end
			endcase
		end
	endtask

	task automatic build_big_list(input bit overflow);
		logic [DATA_W-1:0] dominant;
		dominant = $urandom;
		list_buf.delete();
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (i < (overflow ? MAX_ITEMS / 2 : MAX_ITEMS / 2 + 1)) begin
				list_buf.insert(list_buf.size(), dominant);
			end else begin
				list_buf.insert(list_buf.size(), dominant ^ (32'h1 << $urandom_range(0, 31)));
			end
		end
		shuffle_head(MAX_ITEMS);
		// dropped beats past a full store would tip the count if they were kept
		if (overflow) begin
			repeat ($urandom_range(1, 6)) list_buf.insert(list_buf.size(), dominant);
		end
	endtask

	initial begin
		int len;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		list_buf = '{32'd5};
		send_list();
		list_buf = '{32'h8000_0000, 32'h7fff_ffff};
		send_list();
		list_buf = '{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000};
		send_list();
		list_buf = '{32'd0, 32'd7, 32'd0, 32'd7};
		send_list();
		list_buf = '{32'd3, 32'd9, 32'd9, 32'd3, 32'd9};
		send_list();
		list_buf = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
		send_list();
		list_buf = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
		send_list();
		wait_drained();

		while (beats_sent < TOTAL_BEATS) begin
			quiet = (beats_sent >= QUIET_FROM);
			if (lists_sent == 25) begin
				build_big_list(1'b0);
			end else if (lists_sent == 50) begin
				build_big_list(1'b1);
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
					: $urandom_range(1, 12);
				build_list(len);
			end
			send_list();
			if (lists_sent == 40) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE_WAIT) @(posedge clk);
		$display("ran %0d lists in %0d beats, including a full store and an overflowing list",
			sb.lists, sb.beats);
		$display("checked %0d results, %0d mismatches, %0d still expected",
			sb.results, sb.mismatches, sb.expected_q.size());
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[sim.f]
src/mef_pkg.sv
src/mef_front.sv
src/mef_queue.sv
src/mef_back.sv
src/majority_element_finder_core.sv
verif/tb.sv
